// ===== rtl/core/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Concurrent assertion shorthands for the scheduler table RTL. They expect a
// clock named clk and an active-low reset named rst_n in the using scope.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tts_pkg.sv =====
// ============================================================================
// tts_pkg
// Shared widths, codes and types of the tick task scheduler table.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

    localparam int OP_W     = 2;
    localparam int HANDLE_W = 8;
    localparam int MS_W     = 16;
    localparam int TIME_W   = 13;
    localparam int COUNT_W  = 8;
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 3;

    localparam int RESULT_LIMIT = 8;

    localparam logic [TIME_W-1:0]  TIME_MAX  = 13'd8191;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD      = 2'd1;
    localparam logic [OP_W-1:0] OP_DISPATCH = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ADDED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_IDLE  = 2'd3;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   delay;
        logic [TIME_W-1:0]   period;
        logic [COUNT_W-1:0]  count;
    } slot_entry_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [SLOT_W-1:0]   slot;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/tts_if.sv =====
// ============================================================================
// tts_if
// Valid/ready channels of the scheduler: request items in, result items out.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface tts_req_if import tts_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [HANDLE_W-1:0] task_handle;
    logic [MS_W-1:0]     delay_ms;
    logic [MS_W-1:0]     repeat_ms;

    modport source (
        output valid, operation, task_handle, delay_ms, repeat_ms,
        input  ready
    );
    modport sink (
        input  valid, operation, task_handle, delay_ms, repeat_ms,
        output ready
    );
endinterface

interface tts_rsp_if import tts_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] task_handle_out;
    logic [SLOT_W-1:0]   slot;
    logic                last;

    modport source (
        output valid, kind, task_handle_out, slot, last,
        input  ready
    );
    modport sink (
        input  valid, kind, task_handle_out, slot, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/tts_div.sv =====
// ============================================================================
// tts_div
// Shared divider by the fixed tick period: a reciprocal multiply whose argument
// is registered at start and whose quotient is then registered from the product.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tts_div import tts_pkg::*; #(
    parameter int DIVISOR = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [MS_W-1:0] dividend,
    output logic            busy,
    output logic            done,
    output logic [MS_W-1:0] quotient
);

    // ceil(2^SH / DIVISOR) is exact for every MS_W-bit dividend when
    // SH = MS_W + clog2(DIVISOR); the reciprocal fits in MS_W + 2 bits
    localparam int LW = $clog2(DIVISOR);
    localparam int SH = MS_W + LW;
    localparam int MW = MS_W + 2;
    localparam int PW = MS_W + MW;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] RECIP_V = MW'(RECIP);

    logic [MS_W-1:0] arg_reg;
    logic [MS_W-1:0] quo_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [PW-1:0] prod;

    assign prod = PW'(arg_reg) * PW'(RECIP_V);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            arg_reg <= dividend;
        end
        if (busy_reg)
        begin
            quo_reg <= MS_W'(prod >> SH);
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    `TTS_ASSERT_IMP(a_done_idle, done_reg, !busy_reg, "divider done while busy")
    `TTS_ASSERT_IMP(a_no_restart, start, !busy_reg, "divider restarted mid-division")

endmodule

`default_nettype wire

// ===== rtl/core/tts_slot_mem.sv =====
// ============================================================================
// tts_slot_mem
// Slot table storage: one write port, one registered read port, and a valid
// bit per slot so that unwritten slots read as free.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tts_slot_mem import tts_pkg::*; #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  slot_entry_t   wr_data,
    input  logic [AW-1:0] rd_addr,
    output slot_entry_t   rd_data
);

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_raw_reg;
    logic        vld_reg [DEPTH];
    logic        rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_raw_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // never-written slot: free, no pending runs
    assign rd_data = rd_vld_reg ? rd_raw_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/core/tick_task_scheduler_table.sv =====
// Tick / dispatch: every slot is visited in order; a tick posts no result, and a
//   dispatch posts its final result to the output register from the flush state.
// Add: a zero handle goes straight to the post; otherwise two passes through the
//   shared reciprocal divider, a free-slot search of up to TASK_SLOTS slots, the post.
// One item at a time, next accepted once back in idle; output stalls hold the sequencer.
// Reset clears the sequencer, the output valid flag and per-slot valid bits (all slots free).
// ============================================================================
// tick_task_scheduler_table
// Cooperative task scheduler table: add, tick and dispatch items walk the slot
// table one slot per cycle under a small sequencer, unless an output stall holds it.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tick_task_scheduler_table import tts_pkg::*; #(
    parameter int TASK_SLOTS = 8,
    parameter int TICK_MS    = 10
) (
    input  logic      clk,
    input  logic      rst_n,
    tts_req_if.sink   req,
    tts_rsp_if.source rsp
);

    localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int NW = $clog2(RESULT_LIMIT + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(TASK_SLOTS - 1);
    localparam logic [NW-1:0] RES_LIM  = NW'(RESULT_LIMIT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_D,
        S_DIV_P,
        S_EXEC,
        S_FLUSH
    } state_t;

    state_t              state_reg,    state_next;
    logic [OP_W-1:0]     op_reg,       op_next;
    logic [HANDLE_W-1:0] hnd_reg,      hnd_next;
    logic [MS_W-1:0]     rep_reg,      rep_next;
    logic [TIME_W-1:0]   dly_reg,      dly_next;
    logic [TIME_W-1:0]   per_reg,      per_next;
    logic [AW-1:0]       idx_reg,      idx_next;
    logic [NW-1:0]       nres_reg,     nres_next;
    result_t             pend_reg,     pend_next;
    logic                pend_vld_reg, pend_vld_next;
    result_t             out_reg,      out_next;
    logic                out_last_reg, out_last_next;
    logic                out_vld_reg,  out_vld_next;

    // slot table
    logic        wr_en;
    slot_entry_t wr_data;
    slot_entry_t ent;

    // divider
    logic            div_start;
    logic [MS_W-1:0] div_dividend;
    logic            div_busy;
    logic            div_done;
    logic [MS_W-1:0] div_q;

    logic [MS_W:0]      q_inc;
    logic [TIME_W-1:0]  dly_sat;
    logic [TIME_W-1:0]  per_sat;
    logic [TIME_W-1:0]  dly_dec;
    logic [COUNT_W-1:0] cnt_dec;
    logic [COUNT_W-1:0] cnt_inc;
    logic               hit;
    logic               out_free;
    logic               adv;

    tts_slot_mem #(
        .DEPTH (TASK_SLOTS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_addr (idx_next),
        .rd_data (ent)
    );

    tts_div #(
        .DIVISOR (TICK_MS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign q_inc   = {1'b0, div_q} + 17'd1;
    assign dly_sat = (q_inc > 17'(TIME_MAX)) ? TIME_MAX : q_inc[TIME_W-1:0];
    assign per_sat = (div_q > 16'(TIME_MAX)) ? TIME_MAX : div_q[TIME_W-1:0];
    assign dly_dec = ent.delay - 1'b1;
    assign cnt_dec = ent.count - 1'b1;
    assign cnt_inc = (ent.count == COUNT_MAX) ? COUNT_MAX : ent.count + 1'b1;
    assign hit     = (ent.count != '0) && (nres_reg < RES_LIM);
    assign out_free = !out_vld_reg || rsp.ready;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        hnd_next      = hnd_reg;
        rep_next      = rep_reg;
        dly_next      = dly_reg;
        per_next      = per_reg;
        idx_next      = idx_reg;
        nres_next     = nres_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        out_vld_next  = out_vld_reg && !rsp.ready;
        wr_en         = 1'b0;
        wr_data       = ent;
        div_start     = 1'b0;
        div_dividend  = req.delay_ms;
        adv           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next       = req.operation;
                    hnd_next      = req.task_handle;
                    rep_next      = req.repeat_ms;
                    idx_next      = '0;
                    nres_next     = '0;
                    pend_vld_next = 1'b0;
                    case (req.operation)
                        OP_TICK, OP_DISPATCH:
                        begin
                            state_next = S_EXEC;
                        end
                        OP_ADD:
                        begin
                            if (req.task_handle == '0)
                            begin
                                pend_next     = '{kind: KIND_FULL, handle: '0, slot: '0};
                                pend_vld_next = 1'b1;
                                state_next    = S_FLUSH;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV_D;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_DIV_D:
            begin
                if (div_done)
                begin
                    dly_next     = dly_sat;
                    div_start    = 1'b1;
                    div_dividend = rep_reg;
                    state_next   = S_DIV_P;
                end
            end

            S_DIV_P:
            begin
                if (div_done)
                begin
                    per_next   = per_sat;
                    idx_next   = '0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (op_reg)
                    OP_TICK:
                    begin
                        if ((ent.handle != '0) && (ent.delay != '0))
                        begin
                            wr_en = 1'b1;
                            if (dly_dec == '0)
                            begin
                                wr_data.count = cnt_inc;
                                // one-shot (period zero) holds at zero
                                wr_data.delay = ent.period;
                            end
                            else
                            begin
                                wr_data.delay = dly_dec;
                            end
                        end
                        adv = 1'b1;
                    end
                    OP_ADD:
                    begin
                        if (ent.handle == '0)
                        begin
                            wr_en         = 1'b1;
                            wr_data       = '{handle: hnd_reg, delay: dly_reg,
                                              period: per_reg, count: '0};
                            pend_next     = '{kind: KIND_ADDED, handle: hnd_reg,
                                              slot: SLOT_W'(idx_reg)};
                            pend_vld_next = 1'b1;
                            state_next    = S_FLUSH;
                        end
                        else if (idx_reg == LAST_IDX)
                        begin
                            pend_next     = '{kind: KIND_FULL, handle: '0, slot: '0};
                            pend_vld_next = 1'b1;
                            state_next    = S_FLUSH;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    OP_DISPATCH:
                    begin
                        if (!hit)
                        begin
                            adv = 1'b1;
                        end
                        else if (!pend_vld_reg || out_free)
                        begin
                            // a new hit means the held result is not the final one
                            if (pend_vld_reg)
                            begin
                                out_next      = pend_reg;
                                out_last_next = 1'b0;
                                out_vld_next  = 1'b1;
                            end
                            pend_next     = '{kind: KIND_RUN, handle: ent.handle,
                                              slot: SLOT_W'(idx_reg)};
                            pend_vld_next = 1'b1;
                            nres_next     = nres_reg + 1'b1;
                            wr_en         = 1'b1;
                            wr_data.count = cnt_dec;
                            if ((ent.period == '0) && (cnt_dec == '0))
                            begin
                                wr_data.handle = '0;
                                wr_data.delay  = '0;
                            end
                            adv = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase

                if (adv)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = (op_reg == OP_TICK) ? S_IDLE : S_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_next      = pend_vld_reg ? pend_reg
                                                 : '{kind: KIND_IDLE, handle: '0, slot: '0};
                    out_last_next = 1'b1;
                    out_vld_next  = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            idx_reg      <= '0;
            nres_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
            idx_reg      <= idx_next;
            nres_reg     <= nres_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        hnd_reg      <= hnd_next;
        rep_reg      <= rep_next;
        dly_reg      <= dly_next;
        per_reg      <= per_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_vld_reg;
    assign rsp.kind            = out_reg.kind;
    assign rsp.task_handle_out = out_reg.handle;
    assign rsp.slot            = out_reg.slot;
    assign rsp.last            = out_last_reg;

    `TTS_ASSERT_IMP(a_idle_no_pend, state_reg == S_IDLE, !pend_vld_reg,
        "held result left behind")
    `TTS_ASSERT_IMP(a_single_final,
        rsp.valid && (rsp.kind == KIND_IDLE || rsp.kind == KIND_ADDED || rsp.kind == KIND_FULL),
        rsp.last, "single-result item not marked last")
    `TTS_ASSERT_IMP(a_div_owner, div_busy || div_done,
        state_reg == S_DIV_D || state_reg == S_DIV_P, "divider active outside add")
    `TTS_ASSERT_NXT(a_nres_cap, state_reg == S_EXEC, nres_reg <= RES_LIM,
        "too many dispatch results")

endmodule

`default_nettype wire

// ===== tb/sv/tick_task_scheduler_table_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tick_task_scheduler_table_tb
// Self-checking bench for the scheduler table. Items go in over the request
// channel and results come back over the result channel. A local copy of the
// slot table predicts each result (pinned directed rows give their own), and
// each is compared field by field. The run has two parts: a directed table
// and random traffic. Both channels stall at random outside a gap-free stretch.
// ============================================================================

module tick_task_scheduler_table_tb;
    import tts_pkg::*;

    localparam int SLOTS         = 8;
    localparam int TICK_PERIOD   = 10;
    localparam int RANDOM_ITEMS  = 210;
    localparam int DIRECTED_ROWS = 20;

    // operation code the block ignores
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [SLOT_W-1:0]   slot;
        logic                last;
    } sched_result_t;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [HANDLE_W-1:0] handle;
        logic [MS_W-1:0]     delay_ms;
        logic [MS_W-1:0]     repeat_ms;
        bit                  pinned;
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] exp_handle;
        logic [SLOT_W-1:0]   exp_slot;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sink_ready = 1'b0;
    bit   no_gaps = 1'b0;
    int   errors = 0;

    // item in flight and its typed-in expectation, if any
    bit            pin_on = 1'b0;
    sched_result_t pin_res = '0;

    // local copy of the slot table
    logic [HANDLE_W-1:0] tbl_handle [SLOTS];
    logic [TIME_W-1:0]   tbl_delay  [SLOTS];
    logic [TIME_W-1:0]   tbl_period [SLOTS];
    logic [COUNT_W-1:0]  tbl_count  [SLOTS];

    sched_result_t fresh_results[$];
    sched_result_t due_results[$];

    directed_row_t directed [DIRECTED_ROWS];

    tts_req_if req ();
    tts_rsp_if rsp ();

    assign rsp.ready = sink_ready;

    tick_task_scheduler_table #(
        .TASK_SLOTS (SLOTS),
        .TICK_MS    (TICK_PERIOD)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        sink_ready <= no_gaps || ($urandom_range(0, 99) >= 9);
    end

    function automatic logic [TIME_W-1:0] clamp_ticks(input int unsigned ticks);
        return (ticks > TIME_MAX) ? TIME_MAX : ticks[TIME_W-1:0];
    endfunction

    // Applies one item to the local table and queues the results it causes.
    task automatic advance_table(
        input logic [OP_W-1:0]     op,
        input logic [HANDLE_W-1:0] handle,
        input logic [MS_W-1:0]     delay_ms,
        input logic [MS_W-1:0]     repeat_ms
    );
        sched_result_t runs [RESULT_LIMIT];
        sched_result_t res;
        int            n;
        int            free_slot;
        n = 0;
        free_slot = -1;
        case (op)
            OP_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tbl_handle[i] != 0 && tbl_delay[i] != 0)
                    begin
                        tbl_delay[i] = tbl_delay[i] - 1'b1;
                        if (tbl_delay[i] == 0)
                        begin
                            if (tbl_count[i] != COUNT_MAX)
                                tbl_count[i] = tbl_count[i] + 1'b1;
                            if (tbl_period[i] != 0)
                                tbl_delay[i] = tbl_period[i];
                        end
                    end
                end
            end
            OP_ADD:
            begin
                res = '{KIND_FULL, '0, '0, 1'b1};
                if (handle != 0)
                begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (tbl_handle[i] == 0)
                            free_slot = i;
                end
                if (free_slot >= 0)
                begin
                    tbl_handle[free_slot] = handle;
                    tbl_delay[free_slot]  = clamp_ticks(delay_ms / TICK_PERIOD + 1);
                    tbl_period[free_slot] = clamp_ticks(repeat_ms / TICK_PERIOD);
                    tbl_count[free_slot]  = '0;
                    res = '{KIND_ADDED, handle, SLOT_W'(free_slot), 1'b1};
                end
                fresh_results.push_back(res);
            end
            OP_DISPATCH:
            begin
                for (int i = 0; i < SLOTS && n < RESULT_LIMIT; i++)
                begin
                    if (tbl_count[i] != 0)
                    begin
                        runs[n] = '{KIND_RUN, tbl_handle[i], SLOT_W'(i), 1'b0};
                        n++;
                        tbl_count[i] = tbl_count[i] - 1'b1;
                        // one-shot task leaves the table once fully served
                        if (tbl_period[i] == 0 && tbl_count[i] == 0)
                        begin
                            tbl_handle[i] = '0;
                            tbl_delay[i]  = '0;
                        end
                    end
                end
                if (n == 0)
                    fresh_results.push_back('{KIND_IDLE, '0, '0, 1'b1});
                for (int k = 0; k < n; k++)
                begin
                    res = runs[k];
                    res.last = (k == n - 1);
                    fresh_results.push_back(res);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Results are checked before the item accepted at the same edge is predicted.
    always @(posedge clk)
    begin
        sched_result_t got;
        sched_result_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.kind, rsp.task_handle_out, rsp.slot, rsp.last};
                if (due_results.size() == 0)
                begin
                    $display(
                        "%0t: expected no result, got kind %0d handle %0d slot %0d last %0d",
                        $time, got.kind, got.handle, got.slot, got.last);
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    compare_field("kind", 32'(want.kind), 32'(got.kind));
                    compare_field("task_handle_out", 32'(want.handle), 32'(got.handle));
                    compare_field("slot", 32'(want.slot), 32'(got.slot));
                    compare_field("last", 32'(want.last), 32'(got.last));
                end
            end
            if (req.valid && req.ready)
            begin
                fresh_results.delete();
                advance_table(req.operation, req.task_handle, req.delay_ms, req.repeat_ms);
                if (pin_on)
                    due_results.push_back(pin_res);
                else
                    foreach (fresh_results[k])
                        due_results.push_back(fresh_results[k]);
            end
        end
    end

    task automatic send_request(
        input logic [OP_W-1:0]     op,
        input logic [HANDLE_W-1:0] handle,
        input logic [MS_W-1:0]     delay_ms,
        input logic [MS_W-1:0]     repeat_ms,
        input bit                  pinned,
        input sched_result_t       pin
    );
        while (!no_gaps && $urandom_range(0, 99) < 9)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid       <= 1'b1;
        req.operation   <= op;
        req.task_handle <= handle;
        req.delay_ms    <= delay_ms;
        req.repeat_ms   <= repeat_ms;
        pin_on  = pinned;
        pin_res = pin;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic [OP_W-1:0]     op;
        logic [HANDLE_W-1:0] handle;
        logic [MS_W-1:0]     delay_ms;
        logic [MS_W-1:0]     repeat_ms;
        int unsigned         pick;

        req.valid       = 1'b0;
        req.operation   = OP_TICK;
        req.task_handle = '0;
        req.delay_ms    = '0;
        req.repeat_ms   = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_handle[i] = '0;
            tbl_delay[i]  = '0;
            tbl_period[i] = '0;
            tbl_count[i]  = '0;
        end

        directed = '{
            '{OP_DISPATCH, 8'h00, 16'd0,     16'd0,     1'b1, KIND_IDLE,  8'h00, 3'd0},
            '{OP_ADD,      8'h00, 16'd5,     16'd5,     1'b1, KIND_FULL,  8'h00, 3'd0},
            '{OP_ADD,      8'hFF, 16'd0,     16'd0,     1'b1, KIND_ADDED, 8'hFF, 3'd0},
            '{OP_ADD,      8'h01, 16'hFFFF,  16'hFFFF,  1'b1, KIND_ADDED, 8'h01, 3'd1},
            '{OP_ADD,      8'h80, 16'd10,    16'd10,    1'b0, KIND_ADDED, 8'h00, 3'd0},
            '{OP_ADD,      8'h7F, 16'd9,     16'd9,     1'b0, KIND_ADDED, 8'h00, 3'd0},
            '{OP_ADD,      8'h40, 16'd0,     16'd0,     1'b0, KIND_ADDED, 8'h00, 3'd0},
            '{OP_ADD,      8'h20, 16'd30,    16'd0,     1'b0, KIND_ADDED, 8'h00, 3'd0},
            '{OP_ADD,      8'h10, 16'd0,     16'd25,    1'b0, KIND_ADDED, 8'h00, 3'd0},
            '{OP_ADD,      8'h08, 16'd0,     16'd0,     1'b0, KIND_ADDED, 8'h00, 3'd0},
            '{OP_ADD,      8'h04, 16'd0,     16'd0,     1'b1, KIND_FULL,  8'h00, 3'd0},
            '{OP_TICK,     8'h00, 16'd0,     16'd0,     1'b0, KIND_ADDED, 8'h00, 3'd0},
            '{OP_NONE,     8'h55, 16'h1234,  16'h4321,  1'b0, KIND_ADDED, 8'h00, 3'd0},
            '{OP_TICK,     8'h00, 16'd0,     16'd0,     1'b0, KIND_ADDED, 8'h00, 3'd0},
            '{OP_DISPATCH, 8'h00, 16'd0,     16'd0,     1'b0, KIND_ADDED, 8'h00, 3'd0},
            '{OP_ADD,      8'h02, 16'd0,     16'd0,     1'b0, KIND_ADDED, 8'h00, 3'd0},
            '{OP_TICK,     8'h00, 16'd0,     16'd0,     1'b0, KIND_ADDED, 8'h00, 3'd0},
            '{OP_TICK,     8'h00, 16'd0,     16'd0,     1'b0, KIND_ADDED, 8'h00, 3'd0},
            '{OP_DISPATCH, 8'h00, 16'd0,     16'd0,     1'b0, KIND_ADDED, 8'h00, 3'd0},
            '{OP_DISPATCH, 8'h00, 16'd0,     16'd0,     1'b0, KIND_ADDED, 8'h00, 3'd0}
        };

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[r])
            send_request(directed[r].op, directed[r].handle, directed[r].delay_ms,
                         directed[r].repeat_ms, directed[r].pinned,
                         '{directed[r].kind, directed[r].exp_handle, directed[r].exp_slot, 1'b1});

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_gaps   = (n >= 80 && n < 160);
            pick      = $urandom_range(0, 99);
            handle    = HANDLE_W'($urandom_range(0, 255));
            delay_ms  = MS_W'($urandom);
            repeat_ms = MS_W'($urandom);
            if (pick < 40)
                op = OP_TICK;
            else if (pick < 62)
                op = OP_ADD;
            else if (pick < 95)
                op = OP_DISPATCH;
            else
                op = OP_NONE;
            if (op == OP_ADD)
            begin
                if ($urandom_range(0, 15) != 0)
                    handle = HANDLE_W'($urandom_range(1, 255));
                // mostly short one-shot tasks so that slots keep recycling
                if ($urandom_range(0, 99) >= 5)
                    delay_ms = MS_W'($urandom_range(0, 60));
                pick = $urandom_range(0, 99);
                if (pick < 90)
                    repeat_ms = MS_W'($urandom_range(0, 9));
                else if (pick < 96)
                    repeat_ms = MS_W'($urandom_range(10, 80));
            end
            send_request(op, handle, delay_ms, repeat_ms, 1'b0, '0);
        end
        no_gaps = 1'b0;
        req.valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
